// ===== src/kmrc_pkg.sv =====
// Shared constants, register indexes and character functions for the kmer match counter.
`timescale 1ns / 1ps
package kmrc_pkg;

  localparam int MAX_KMER_DEFAULT = 32;
  localparam int CHAR_LIMIT       = 32;
  localparam int CHAR_REGS        = 4;
  localparam int CHAR_W           = 8;
  localparam int CHAR_IDX_W       = 5;
  localparam int LEN_W            = 6;
  localparam int CNT_W            = 32;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_KMER_LENGTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHARS_0_7    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHARS_8_15   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHARS_16_23  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CHARS_24_31  = 3'd4;

  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_CASE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_A       = 8'h61;
  localparam logic [CHAR_W-1:0] CH_C       = 8'h63;
  localparam logic [CHAR_W-1:0] CH_G       = 8'h67;
  localparam logic [CHAR_W-1:0] CH_T       = 8'h74;

  function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CH_CASE;
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] complement(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c == CH_A) begin
      r = CH_T;
    end else if (c == CH_T) begin
      r = CH_A;
    end else if (c == CH_C) begin
      r = CH_G;
    end else if (c == CH_G) begin
      r = CH_C;
    end
    return r;
  endfunction

endpackage

// ===== src/kmrc_ifs.sv =====
// Valid/ready channel interfaces for sequence characters and match results.
`timescale 1ns / 1ps
interface kmrc_char_if
  import kmrc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] base_char;
  logic              sequence_start;

  modport source (output valid, output base_char, output sequence_start, input ready);
  modport sink   (input valid, input base_char, input sequence_start, output ready);
endinterface

interface kmrc_result_if
  import kmrc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             forward_hit;
  logic             reverse_hit;
  logic [CNT_W-1:0] match_total;
  logic [CNT_W-1:0] window_total;

  modport source (output valid, output forward_hit, output reverse_hit,
                  output match_total, output window_total, input ready);
  modport sink   (input valid, input forward_hit, input reverse_hit,
                  input match_total, input window_total, output ready);
endinterface

// ===== src/kmrc_cfg.sv =====
// Configuration registers and per-position expected-character tables.
`timescale 1ns / 1ps
module kmrc_cfg
  import kmrc_pkg::*;
#(
  parameter int MaxKmer = MAX_KMER_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output logic [LEN_W-1:0]       eff_len,
  output logic                   pos_en  [MaxKmer],
  output logic [CHAR_W-1:0]      fwd_exp [MaxKmer],
  output logic [CHAR_W-1:0]      rev_exp [MaxKmer]
);

  localparam int LenLimit = (MaxKmer < CHAR_LIMIT) ? MaxKmer : CHAR_LIMIT;

  logic [LEN_W-1:0]                  kmer_length;
  logic [CFG_DATA_W-1:0]             kmer_chars [CHAR_REGS];
  logic [CHAR_REGS*CFG_DATA_W-1:0]   all_chars;
  logic [LEN_W-1:0]                  len_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= LEN_W'(1);
      for (int r = 0; r < CHAR_REGS; r++) begin
        kmer_chars[r] <= '0;
      end
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KMER_LENGTH: kmer_length   <= wr_data[LEN_W-1:0];
        REG_CHARS_0_7:   kmer_chars[0] <= wr_data;
        REG_CHARS_8_15:  kmer_chars[1] <= wr_data;
        REG_CHARS_16_23: kmer_chars[2] <= wr_data;
        REG_CHARS_24_31: kmer_chars[3] <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign all_chars = {kmer_chars[3], kmer_chars[2], kmer_chars[1], kmer_chars[0]};

  always_comb begin
    priority if (kmer_length == '0) begin
      len_clip = LEN_W'(1);
    end else if (kmer_length > LEN_W'(LenLimit)) begin
      len_clip = LEN_W'(LenLimit);
    end else begin
      len_clip = kmer_length;
    end
  end

  always_ff @(posedge clk) begin
    eff_len <= len_clip;
  end

  // Forward table is aligned to window positions: position j holds kmer char len-1-j.
  for (genvar j = 0; j < MaxKmer; j++) begin : g_pos
    if (j < CHAR_LIMIT) begin : g_live
      logic [LEN_W-1:0]      fdiff;
      logic [CHAR_IDX_W-1:0] fidx;
      assign fdiff = len_clip - LEN_W'(1) - LEN_W'(j);
      assign fidx  = fdiff[CHAR_IDX_W-1:0];
      always_ff @(posedge clk) begin
        pos_en[j]  <= LEN_W'(j) < len_clip;
        fwd_exp[j] <= lower_ascii(all_chars[fidx*CHAR_W +: CHAR_W]);
        rev_exp[j] <= complement(lower_ascii(all_chars[j*CHAR_W +: CHAR_W]));
      end
    end else begin : g_dead
      assign pos_en[j]  = 1'b0;
      assign fwd_exp[j] = '0;
      assign rev_exp[j] = '0;
    end
  end

endmodule

// ===== src/kmrc_window.sv =====
// Input stage: character window shift register and sequence fill count.
`timescale 1ns / 1ps
module kmrc_window
  import kmrc_pkg::*;
#(
  parameter int MaxKmer = MAX_KMER_DEFAULT,
  localparam int FillW  = $clog2(MaxKmer + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              advance,
  input  logic [CHAR_W-1:0] base_char,
  input  logic              sequence_start,
  output logic              stage_valid,
  output logic [FillW-1:0]  fill_count,
  output logic [CHAR_W-1:0] char_window [MaxKmer]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      fill_count  <= '0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (accept) begin
        priority if (sequence_start) begin
          fill_count <= FillW'(1);
        end else if (fill_count != FillW'(MaxKmer)) begin
          fill_count <= fill_count + FillW'(1);
        end
      end
    end
  end

  // Shift newest character into position zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      char_window[0] <= lower_ascii(base_char);
      for (int j = 1; j < MaxKmer; j++) begin
        char_window[j] <= char_window[j-1];
      end
    end
  end

endmodule

// ===== src/kmrc_match.sv =====
// Window compare, saturating totals and result register.
`timescale 1ns / 1ps
module kmrc_match
  import kmrc_pkg::*;
#(
  parameter int MaxKmer = MAX_KMER_DEFAULT,
  localparam int FillW  = $clog2(MaxKmer + 1),
  localparam int CmpW   = (FillW > LEN_W) ? FillW : LEN_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              stage_valid,
  input  logic [FillW-1:0]  fill_count,
  input  logic [CHAR_W-1:0] char_window [MaxKmer],
  input  logic [LEN_W-1:0]  eff_len,
  input  logic              pos_en  [MaxKmer],
  input  logic [CHAR_W-1:0] fwd_exp [MaxKmer],
  input  logic [CHAR_W-1:0] rev_exp [MaxKmer],
  input  logic              out_ready,
  output logic              out_free,
  output logic              out_valid,
  output logic              forward_hit,
  output logic              reverse_hit,
  output logic [CNT_W-1:0]  match_total,
  output logic [CNT_W-1:0]  window_total
);

  logic advance;
  logic complete;
  logic fwd_eq;
  logic rev_eq;
  logic pal;
  logic fwd;
  logic rev;

  assign out_free = !out_valid || out_ready;
  assign advance  = stage_valid && out_free;
  assign complete = CmpW'(fill_count) >= CmpW'(eff_len);

  always_comb begin
    fwd_eq = 1'b1;
    rev_eq = 1'b1;
    pal    = 1'b1;
    for (int j = 0; j < MaxKmer; j++) begin
      if (pos_en[j]) begin
        if (char_window[j] != fwd_exp[j]) fwd_eq = 1'b0;
        if (char_window[j] != rev_exp[j]) rev_eq = 1'b0;
        if (fwd_exp[j] != rev_exp[j])     pal    = 1'b0;
      end
    end
    fwd = complete && fwd_eq;
    rev = complete && rev_eq && !pal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      match_total  <= '0;
      window_total <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance && complete) begin
        if (window_total != '1) begin
          window_total <= window_total + CNT_W'(1);
        end
        if ((fwd || rev) && match_total != '1) begin
          match_total <= match_total + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      forward_hit <= fwd;
      reverse_hit <= rev;
    end
  end

endmodule

// ===== src/kmer_revcomp_match_counter.sv =====
// Top level: kmer and reverse-complement match counter over a character stream.
//
//   channel  | dir | payload                                            | handshake
//   chars    | in  | base_char[7:0], sequence_start                     | valid/ready
//   results  | out | forward_hit, reverse_hit, match_total, window_total | valid/ready
//   config   | in  | wr_index[2:0], wr_data[63:0]                       | wr_en
//
// One item per cycle sustained while results are taken; a result passes the window stage, then the result register.
// The path is an input window stage, then a parallel compare into the result register.
// Tables derived from configuration are registered again after the configuration registers take a write.
// rst is synchronous, active high; the window contents need no clearing.
// A stalled result holds the window stage, which then holds off new items.
`timescale 1ns / 1ps
module kmer_revcomp_match_counter
  import kmrc_pkg::*;
#(
  parameter int MaxKmer = MAX_KMER_DEFAULT,
  localparam int FillW  = $clog2(MaxKmer + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  kmrc_char_if.sink              chars,
  kmrc_result_if.source          results,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  logic              accept;
  logic              advance;
  logic              out_free;
  logic              stage_valid;
  logic [FillW-1:0]  fill_count;
  logic [CHAR_W-1:0] char_window [MaxKmer];
  logic [LEN_W-1:0]  eff_len;
  logic              pos_en  [MaxKmer];
  logic [CHAR_W-1:0] fwd_exp [MaxKmer];
  logic [CHAR_W-1:0] rev_exp [MaxKmer];

  assign chars.ready = !stage_valid || out_free;
  assign accept      = chars.valid && chars.ready;
  assign advance     = stage_valid && out_free;

  kmrc_cfg #(.MaxKmer(MaxKmer)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .eff_len  (eff_len),
    .pos_en   (pos_en),
    .fwd_exp  (fwd_exp),
    .rev_exp  (rev_exp)
  );

  kmrc_window #(.MaxKmer(MaxKmer)) u_window (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .advance        (advance),
    .base_char      (chars.base_char),
    .sequence_start (chars.sequence_start),
    .stage_valid    (stage_valid),
    .fill_count     (fill_count),
    .char_window    (char_window)
  );

  kmrc_match #(.MaxKmer(MaxKmer)) u_match (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .fill_count   (fill_count),
    .char_window  (char_window),
    .eff_len      (eff_len),
    .pos_en       (pos_en),
    .fwd_exp      (fwd_exp),
    .rev_exp      (rev_exp),
    .out_ready    (results.ready),
    .out_free     (out_free),
    .out_valid    (results.valid),
    .forward_hit  (results.forward_hit),
    .reverse_hit  (results.reverse_hit),
    .match_total  (results.match_total),
    .window_total (results.window_total)
  );

`ifndef SYNTHESIS
  a_hits_exclusive: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.forward_hit && results.reverse_hit))
    else $error("forward and reverse hit both set");

  a_match_le_window: assert property (@(posedge clk) disable iff (rst)
    results.match_total <= results.window_total)
    else $error("match total exceeds window total");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stage_valid && results.valid && !results.ready |-> !chars.ready)
    else $error("item accepted while window stage is stalled");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FillW'(MaxKmer))
    else $error("fill count beyond window depth");
`endif

endmodule
